### rtl/at_command_line_parser_macros.svh
// ----------------------------------------------------------------------------
// AT command line parser - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_PARSER_MACROS_SVH
`define AT_COMMAND_LINE_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ATP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define ATP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/atp_pkg.sv
// ----------------------------------------------------------------------------
// atp_pkg
// Constants, codes, request type and character helpers for the AT parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atp_pkg;

    localparam int NAME_LEN   = 16;
    localparam int ARGS_LEN   = 32;
    localparam int NAME_AW    = $clog2(NAME_LEN);
    localparam int ARG_AW     = $clog2(ARGS_LEN);
    localparam int NAME_CNT_W = $clog2(NAME_LEN + 1);
    localparam int ARG_CNT_W  = $clog2(ARGS_LEN + 1);
    localparam int IDX_W      = (NAME_CNT_W > ARG_CNT_W) ? NAME_CNT_W : ARG_CNT_W;

    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 2;
    localparam int TICK_W     = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

    // result kinds
    localparam logic [CODE_W-1:0] KIND_NAME = 2'd0;
    localparam logic [CODE_W-1:0] KIND_ARG  = 2'd1;
    localparam logic [CODE_W-1:0] KIND_DONE = 2'd2;
    localparam logic [CODE_W-1:0] KIND_ERR  = 2'd3;

    // command types
    localparam logic [CODE_W-1:0] CMD_EXEC = 2'd0;
    localparam logic [CODE_W-1:0] CMD_GET  = 2'd1;
    localparam logic [CODE_W-1:0] CMD_SET  = 2'd2;
    localparam logic [CODE_W-1:0] CMD_TEST = 2'd3;

    // error codes
    localparam logic [CODE_W-1:0] ERR_POS     = 2'd0;
    localparam logic [CODE_W-1:0] ERR_PARAM   = 2'd1;
    localparam logic [CODE_W-1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [CODE_W-1:0] ERR_OVER    = 2'd3;

    // input op
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // characters
    localparam logic [CHAR_W-1:0] CH_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LOW   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_T       = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LOW   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_Z       = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_Z_LOW   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QMARK   = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    // request from parser to output sequencer
    typedef struct packed {
        logic                  start;
        logic                  is_err;
        logic [CODE_W-1:0]     err_code;
        logic [CODE_W-1:0]     cmd_type;
        logic [NAME_CNT_W-1:0] n_name;
        logic [ARG_CNT_W-1:0]  n_arg;
    } atp_req_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_A) && (c <= CH_Z);
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_A_LOW) && (c <= CH_Z_LOW);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic arg_ok(input logic [CHAR_W-1:0] c);
        return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_QUOTE) ||
               (c == CH_MINUS) || (c == CH_DOT) || (c == CH_COLON) || (c == CH_COMMA);
    endfunction

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        return is_lower(c) ? (c - CASE_DELTA) : c;
    endfunction

endpackage

### rtl/atp_ram.sv
// ----------------------------------------------------------------------------
// atp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/atp_parser.sv
// ----------------------------------------------------------------------------
// atp_parser
// Line parser: phase, counters, timeout timer; fills the name/argument RAMs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atp_parser import atp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  in_op,
    input  logic [CHAR_W-1:0]     in_byte,
    input  logic                  cfg_we,
    input  logic [TICK_W-1:0]     cfg_wdata,
    output logic                  name_we,
    output logic [NAME_AW-1:0]    name_waddr,
    output logic [CHAR_W-1:0]     name_wdata,
    output logic                  arg_we,
    output logic [ARG_AW-1:0]     arg_waddr,
    output logic [CHAR_W-1:0]     arg_wdata,
    output atp_req_t              req
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_PLUS,
        PH_NAME,
        PH_ARGS,
        PH_CR
    } phase_t;

    phase_t                phase_reg,   phase_next;
    logic [NAME_CNT_W-1:0] name_cnt_reg, name_cnt_next;
    logic [ARG_CNT_W-1:0]  arg_cnt_reg,  arg_cnt_next;
    logic [CODE_W-1:0]     ctype_reg,   ctype_next;
    logic                  timer_on_reg, timer_on_next;
    logic [TICK_W-1:0]     tick_reg,    tick_next;
    logic [TICK_W-1:0]     timeout_reg;
    atp_req_t              req_reg,     req_next;

    logic                  do_fail;
    logic                  do_finish;
    logic [CODE_W-1:0]     fail_code;
    logic [CODE_W-1:0]     fin_type;
    logic [NAME_CNT_W-1:0] fin_names;
    logic [TICK_W-1:0]     tick_inc;

    assign tick_inc = tick_reg + 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        name_cnt_next = name_cnt_reg;
        arg_cnt_next  = arg_cnt_reg;
        ctype_next    = ctype_reg;
        timer_on_next = timer_on_reg;
        tick_next     = tick_reg;
        req_next      = '0;
        do_fail       = 1'b0;
        do_finish     = 1'b0;
        fail_code     = ERR_POS;
        fin_type      = ctype_reg;
        fin_names     = name_cnt_reg;
        name_we       = 1'b0;
        arg_we        = 1'b0;

        if (in_fire && (in_op == OP_TICK))
        begin
            if (timer_on_reg)
            begin
                tick_next = tick_inc;
                // wrap to zero also counts as expiry
                if ((tick_inc >= timeout_reg) || (tick_inc == '0))
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TIMEOUT;
                end
            end
        end
        else if (in_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if ((in_byte == CH_A) || (in_byte == CH_A_LOW))
                    begin
                        phase_next    = PH_HEAD;
                        name_cnt_next = '0;
                        arg_cnt_next  = '0;
                    end
                end
                PH_HEAD:
                begin
                    if ((in_byte == CH_T) || (in_byte == CH_T_LOW))
                    begin
                        phase_next    = PH_PLUS;
                        timer_on_next = 1'b1;
                        tick_next     = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PLUS:
                begin
                    priority if (in_byte == CH_PLUS)
                    begin
                        phase_next = PH_NAME;
                    end
                    else if (in_byte == CH_CR)
                    begin
                        do_finish = 1'b1;
                        fin_type  = CMD_EXEC;
                        fin_names = '0;
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_POS;
                    end
                end
                PH_NAME:
                begin
                    priority if ((in_byte == CH_QMARK) && (name_cnt_reg != '0))
                    begin
                        ctype_next = CMD_GET;
                        phase_next = PH_CR;
                    end
                    else if ((in_byte == CH_EQUAL) && (name_cnt_reg != '0))
                    begin
                        phase_next = PH_ARGS;
                    end
                    else if ((in_byte == CH_CR) && (name_cnt_reg != '0))
                    begin
                        do_finish = 1'b1;
                        fin_type  = CMD_EXEC;
                    end
                    else if (is_upper(in_byte) || is_lower(in_byte))
                    begin
                        if (name_cnt_reg >= NAME_CNT_W'(NAME_LEN))
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OVER;
                        end
                        else
                        begin
                            name_we       = 1'b1;
                            name_cnt_next = name_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_POS;
                    end
                end
                PH_ARGS:
                begin
                    priority if ((in_byte == CH_QMARK) && (arg_cnt_reg == '0))
                    begin
                        ctype_next = CMD_TEST;
                        phase_next = PH_CR;
                    end
                    else if ((in_byte == CH_CR) && (arg_cnt_reg != '0))
                    begin
                        do_finish = 1'b1;
                        fin_type  = CMD_SET;
                    end
                    else if (arg_ok(in_byte))
                    begin
                        if (arg_cnt_reg >= ARG_CNT_W'(ARGS_LEN))
                        begin
                            do_fail   = 1'b1;
                            fail_code = ERR_OVER;
                        end
                        else
                        begin
                            ctype_next   = CMD_SET;
                            arg_we       = 1'b1;
                            arg_cnt_next = arg_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_PARAM;
                    end
                end
                PH_CR:
                begin
                    if (in_byte == CH_CR)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_POS;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (do_finish)
        begin
            ctype_next        = fin_type;
            req_next.start    = 1'b1;
            req_next.cmd_type = fin_type;
            req_next.n_name   = fin_names;
            req_next.n_arg    = (fin_type == CMD_SET) ? arg_cnt_reg : '0;
        end
        else if (do_fail)
        begin
            req_next.start    = 1'b1;
            req_next.is_err   = 1'b1;
            req_next.err_code = fail_code;
        end

        if (do_finish || do_fail)
        begin
            phase_next    = PH_IDLE;
            name_cnt_next = '0;
            arg_cnt_next  = '0;
            timer_on_next = 1'b0;
            tick_next     = '0;
        end
    end

    assign name_waddr = name_cnt_reg[NAME_AW-1:0];
    assign name_wdata = to_upper(in_byte);
    assign arg_waddr  = arg_cnt_reg[ARG_AW-1:0];
    assign arg_wdata  = in_byte;
    assign req        = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            name_cnt_reg <= '0;
            arg_cnt_reg  <= '0;
            ctype_reg    <= CMD_EXEC;
            timer_on_reg <= 1'b0;
            tick_reg     <= '0;
            timeout_reg  <= TIMEOUT_RESET;
            req_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            name_cnt_reg <= name_cnt_next;
            arg_cnt_reg  <= arg_cnt_next;
            ctype_reg    <= ctype_next;
            timer_on_reg <= timer_on_next;
            tick_reg     <= tick_next;
            req_reg      <= req_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

endmodule

### rtl/atp_drain.sv
// ----------------------------------------------------------------------------
// atp_drain
// Result sequencer: reads the stores back and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atp_drain import atp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  atp_req_t              req,
    output logic                  busy,
    output logic                  name_re,
    output logic [NAME_AW-1:0]    name_raddr,
    input  logic [CHAR_W-1:0]     name_rdata,
    output logic                  arg_re,
    output logic [ARG_AW-1:0]     arg_raddr,
    input  logic [CHAR_W-1:0]     arg_rdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CODE_W-1:0]     out_kind,
    output logic [CHAR_W-1:0]     out_char,
    output logic [CODE_W-1:0]     out_type,
    output logic [CODE_W-1:0]     out_code,
    output logic                  out_last
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_NAME,
        D_ARG,
        D_FINAL
    } dstate_t;

    dstate_t               state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [NAME_CNT_W-1:0] n_name_reg;
    logic [ARG_CNT_W-1:0]  n_arg_reg;
    logic                  is_err_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [CODE_W-1:0]     type_reg;
    logic                  pend_reg;
    logic                  valid_reg;
    logic [CODE_W-1:0]     kind_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [CODE_W-1:0]     otype_reg;
    logic [CODE_W-1:0]     ocode_reg;
    logic                  last_reg;

    logic out_free;
    logic name_left;
    logic arg_left;
    logic rd_issue;

    assign out_free  = !valid_reg || out_ready;
    assign name_left = idx_reg < IDX_W'(n_name_reg);
    assign arg_left  = idx_reg < IDX_W'(n_arg_reg);

    // one read in flight; RAM output holds until it is moved out
    assign rd_issue   = !pend_reg && (((state_reg == D_NAME) && name_left) ||
                                      ((state_reg == D_ARG) && arg_left));
    assign name_re    = rd_issue && (state_reg == D_NAME);
    assign arg_re     = rd_issue && (state_reg == D_ARG);
    assign name_raddr = idx_reg[NAME_AW-1:0];
    assign arg_raddr  = idx_reg[ARG_AW-1:0];
    assign busy       = (state_reg != D_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= D_IDLE;
            idx_reg    <= '0;
            n_name_reg <= '0;
            n_arg_reg  <= '0;
            is_err_reg <= 1'b0;
            code_reg   <= ERR_POS;
            type_reg   <= CMD_EXEC;
            pend_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            kind_reg   <= KIND_NAME;
            char_reg   <= '0;
            otype_reg  <= CMD_EXEC;
            ocode_reg  <= ERR_POS;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (valid_reg && out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (rd_issue)
            begin
                pend_reg <= 1'b1;
                idx_reg  <= idx_reg + 1'b1;
            end
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        idx_reg    <= '0;
                        n_name_reg <= req.n_name;
                        n_arg_reg  <= req.n_arg;
                        is_err_reg <= req.is_err;
                        code_reg   <= req.err_code;
                        type_reg   <= req.cmd_type;
                        priority if (req.is_err)
                        begin
                            state_reg <= D_FINAL;
                        end
                        else if (req.n_name != '0)
                        begin
                            state_reg <= D_NAME;
                        end
                        else if (req.n_arg != '0)
                        begin
                            state_reg <= D_ARG;
                        end
                        else
                        begin
                            state_reg <= D_FINAL;
                        end
                    end
                end
                D_NAME:
                begin
                    if (pend_reg && out_free)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_NAME;
                        char_reg  <= name_rdata;
                        otype_reg <= CMD_EXEC;
                        ocode_reg <= ERR_POS;
                        last_reg  <= 1'b0;
                        pend_reg  <= 1'b0;
                        if (!name_left)
                        begin
                            idx_reg   <= '0;
                            state_reg <= (n_arg_reg != '0) ? D_ARG : D_FINAL;
                        end
                    end
                end
                D_ARG:
                begin
                    if (pend_reg && out_free)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= KIND_ARG;
                        char_reg  <= arg_rdata;
                        otype_reg <= CMD_EXEC;
                        ocode_reg <= ERR_POS;
                        last_reg  <= 1'b0;
                        pend_reg  <= 1'b0;
                        if (!arg_left)
                        begin
                            state_reg <= D_FINAL;
                        end
                    end
                end
                D_FINAL:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        kind_reg  <= is_err_reg ? KIND_ERR : KIND_DONE;
                        char_reg  <= '0;
                        otype_reg <= is_err_reg ? CMD_EXEC : type_reg;
                        ocode_reg <= is_err_reg ? code_reg : ERR_POS;
                        last_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_char  = char_reg;
    assign out_type  = otype_reg;
    assign out_code  = ocode_reg;
    assign out_last  = last_reg;

endmodule

### rtl/at_command_line_parser.sv
// ----------------------------------------------------------------------------
// at_command_line_parser
// AT command line recogniser with a streaming result port.
// ----------------------------------------------------------------------------
// Feed received bytes (tuser = 0) and timer ticks (tuser = 1) into the slave
// port. While a line is being parsed the block takes one request per cycle;
// the name letters (upper-cased) and argument bytes go into two small
// synchronous RAMs as they arrive. On CR of a valid line the block stalls its
// input and plays the command back on the master port: name bytes, then the
// argument bytes of a set command, then one done record carrying the command
// type, tlast on the done record. A malformed line, a store overflow or a
// timer expiry gives one error record with tlast instead and returns to idle.
// The playback is paced by the RAM read port: the command is handed over,
// then each stored byte is read and moved into the output register, then
// the closing record is written; for a command or an error the input is
// held throughout, and longer while the sink holds tready low. The closing
// record waits in the output register, so parsing of the next line resumes
// while it is taken.
// The stores need no clearing after reset; the block is ready at once.
// timeout_ticks is loaded through the cfg channel (always ready) and counts
// ticks from AT; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module at_command_line_parser import atp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: timeout_ticks
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TICK_W-1:0]     cfg_data,
    // input requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] byte_value
    input  logic [0:0]            s_axis_tuser,   // [0] op
    // result requests
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] char_value, [9:8] cmd_type,
                                                  // [11:10] error_code, [15:12] zero
    output logic [CODE_W-1:0]     m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast    // last
);

    atp_req_t             req;
    logic                 drain_busy;
    logic                 in_fire;

    logic                 name_we;
    logic [NAME_AW-1:0]   name_waddr;
    logic [CHAR_W-1:0]    name_wdata;
    logic                 name_re;
    logic [NAME_AW-1:0]   name_raddr;
    logic [CHAR_W-1:0]    name_rdata;

    logic                 arg_we;
    logic [ARG_AW-1:0]    arg_waddr;
    logic [CHAR_W-1:0]    arg_wdata;
    logic                 arg_re;
    logic [ARG_AW-1:0]    arg_raddr;
    logic [CHAR_W-1:0]    arg_rdata;

    logic [CHAR_W-1:0]    out_char;
    logic [CODE_W-1:0]    out_type;
    logic [CODE_W-1:0]    out_code;

    // Input is held off while a command plays back and in the hand-over
    // cycle, so the RAMs are never written while being read back.
    assign s_axis_tready = !drain_busy && !req.start;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    atp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_op      (s_axis_tuser[0]),
        .in_byte    (s_axis_tdata),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_wdata  (cfg_data),
        .name_we    (name_we),
        .name_waddr (name_waddr),
        .name_wdata (name_wdata),
        .arg_we     (arg_we),
        .arg_waddr  (arg_waddr),
        .arg_wdata  (arg_wdata),
        .req        (req)
    );

    atp_ram #(
        .DEPTH (NAME_LEN),
        .WIDTH (CHAR_W)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .re    (name_re),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    atp_ram #(
        .DEPTH (ARGS_LEN),
        .WIDTH (CHAR_W)
    ) u_arg_ram (
        .clk   (clk),
        .we    (arg_we),
        .waddr (arg_waddr),
        .wdata (arg_wdata),
        .re    (arg_re),
        .raddr (arg_raddr),
        .rdata (arg_rdata)
    );

    atp_drain u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (drain_busy),
        .name_re    (name_re),
        .name_raddr (name_raddr),
        .name_rdata (name_rdata),
        .arg_re     (arg_re),
        .arg_raddr  (arg_raddr),
        .arg_rdata  (arg_rdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_char   (out_char),
        .out_type   (out_type),
        .out_code   (out_code),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CHAR_W - 2 * CODE_W){1'b0}},
                           out_code, out_type, out_char};

endmodule

### rtl/atp_checker.sv
// ----------------------------------------------------------------------------
// atp_checker
// Port-level checks on the AT parser result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "at_command_line_parser_macros.svh"

module atp_checker import atp_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [CODE_W-1:0]     m_axis_tuser,
    input logic                  m_axis_tlast
);

    logic                         closing;
    logic                         last_ok;
    logic                         name_rec;
    logic                         name_upper;
    logic                         byte_rec;
    logic                         upper_clear;
    logic                         mid_cmd;
    logic                         out_stall;
    logic [OUT_DATA_W+CODE_W+1:0] out_word;

    assign closing     = (m_axis_tuser == KIND_DONE) || (m_axis_tuser == KIND_ERR);
    assign last_ok     = (m_axis_tlast == closing);
    assign name_rec    = m_axis_tvalid && (m_axis_tuser == KIND_NAME);
    assign name_upper  = is_upper(m_axis_tdata[CHAR_W-1:0]);
    assign byte_rec    = m_axis_tvalid &&
                         ((m_axis_tuser == KIND_NAME) || (m_axis_tuser == KIND_ARG));
    assign upper_clear = (m_axis_tdata[OUT_DATA_W-1:CHAR_W] == '0);
    assign mid_cmd     = m_axis_tvalid && !m_axis_tlast;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_word    = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // tlast exactly on done and error records
    `ATP_ASSERT_SAME(a_last_on_close, clk, rst_n, m_axis_tvalid, last_ok, "tlast mismatch")

    // name bytes come out upper case
    `ATP_ASSERT_SAME(a_name_upper, clk, rst_n, name_rec, name_upper, "name byte not upper case")

    // byte records carry no type or error code
    `ATP_ASSERT_SAME(a_byte_clean, clk, rst_n, byte_rec, upper_clear, "stray bits on byte")

    // no input taken mid-playback
    `ATP_ASSERT_SAME(a_stall_mid_cmd, clk, rst_n, mid_cmd, !s_axis_tready, "input mid-playback")

    // stalled result holds
    `ATP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(out_word), "result not held")

endmodule

bind at_command_line_parser atp_checker u_atp_checker (.*);
